[rtl/nik_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package nik_pkg;

  // Field and arithmetic widths
  localparam int ANGLE_WIDTH = 16;
  localparam int SLOT_W      = 16;
  localparam int MW          = (ANGLE_WIDTH > SLOT_W) ? ANGLE_WIDTH : SLOT_W;
  localparam int DIFF_W      = MW + 1;
  localparam int PROD_W      = DIFF_W + SLOT_W;
  localparam int FRAC_SH     = 12;
  localparam int NUM_W       = PROD_W + 1 + FRAC_SH;
  localparam int YNUM_W      = DIFF_W + FRAC_SH;
  localparam int QUO_W       = MW + 2;
  localparam int SUM_W       = QUO_W + 2;
  localparam int DMAG_W      = 32;
  localparam int GMAG_W      = 16;
  localparam int THR_W       = 32;
  localparam int PADDR_W     = 6;
  localparam int PDATA_W     = 64;
  localparam int DIV_LAT     = QUO_W + 3;

  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [SLOT_W-1:0]      slot_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SINGULAR    = 3'd1,
    ST_POSE_RANGE  = 3'd2,
    ST_OVERFLOW    = 3'd3,
    ST_MOTOR_RANGE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_COUPLING  = 3'd0,
    REG_GAIN_THR  = 3'd1,
    REG_POSE_CTR  = 3'd2,
    REG_MOTOR_CTR = 3'd3,
    REG_POSE_LO   = 3'd4,
    REG_POSE_HI   = 3'd5,
    REG_MOTOR_LO  = 3'd6,
    REG_MOTOR_HI  = 3'd7
  } reg_idx_t;

  localparam logic [63:0] RST_COUPLING = 64'h1000_0000_0000_1000;
  localparam logic [47:0] RST_GAIN_THR = 48'h0000_0001_1000;
  localparam logic [47:0] RST_LO       = 48'h8000_8000_8000;
  localparam logic [47:0] RST_HI       = 48'h7FFF_7FFF_7FFF;

  typedef struct packed {
    angle_t pitch_angle;
    angle_t roll_angle;
    angle_t yaw_angle;
  } in_word_t;

  typedef struct packed {
    angle_t  first_motor;
    angle_t  second_motor;
    angle_t  third_motor;
    status_t status_code;
  } out_word_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    slot_t              c11;
    slot_t              c12;
    slot_t              c21;
    slot_t              c22;
    logic               det_neg;
    logic [DMAG_W-1:0]  det_mag;
    logic               gain_neg;
    logic [GMAG_W-1:0]  gain_mag;
    logic               singular;
    slot_t [2:0]        pose_ctr;
    slot_t [2:0]        motor_ctr;
    slot_t [2:0]        pose_lo;
    slot_t [2:0]        pose_hi;
    slot_t [2:0]        motor_lo;
    slot_t [2:0]        motor_hi;
  } cfg_t;

  // Front end to divider handoff
  typedef struct packed {
    logic                     valid;
    logic                     pose_fail;
    logic signed [NUM_W-1:0]  num1;
    logic signed [NUM_W-1:0]  num2;
    logic signed [YNUM_W-1:0] num3;
  } front_t;

endpackage
`default_nettype wire

[rtl/nik_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
module nik_regs import nik_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output cfg_t                    cfg
);

  logic [63:0] coupling_r;
  logic [47:0] gain_thr_r, pose_ctr_r, motor_ctr_r;
  logic [47:0] pose_lo_r, pose_hi_r, motor_lo_r, motor_hi_r;
  logic signed [31:0] p1_r, p2_r;
  logic               det_neg_r;
  logic [DMAG_W-1:0]  det_mag_r;
  logic               gain_neg_r;
  logic [GMAG_W-1:0]  gain_mag_r;
  logic               singular_r;
  logic signed [32:0] det;
  logic [THR_W-1:0]   thr;
  reg_idx_t           idx;

  assign idx = reg_idx_t'(paddr[5:3]);
  assign thr = gain_thr_r[47:16];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coupling_r  <= RST_COUPLING;
      gain_thr_r  <= RST_GAIN_THR;
      pose_ctr_r  <= '0;
      motor_ctr_r <= '0;
      pose_lo_r   <= RST_LO;
      pose_hi_r   <= RST_HI;
      motor_lo_r  <= RST_LO;
      motor_hi_r  <= RST_HI;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_COUPLING:  coupling_r  <= pwdata;
        REG_GAIN_THR:  gain_thr_r  <= pwdata[47:0];
        REG_POSE_CTR:  pose_ctr_r  <= pwdata[47:0];
        REG_MOTOR_CTR: motor_ctr_r <= pwdata[47:0];
        REG_POSE_LO:   pose_lo_r   <= pwdata[47:0];
        REG_POSE_HI:   pose_hi_r   <= pwdata[47:0];
        REG_MOTOR_LO:  motor_lo_r  <= pwdata[47:0];
        REG_MOTOR_HI:  motor_hi_r  <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_COUPLING:  prdata = coupling_r;
      REG_GAIN_THR:  prdata = {16'd0, gain_thr_r};
      REG_POSE_CTR:  prdata = {16'd0, pose_ctr_r};
      REG_MOTOR_CTR: prdata = {16'd0, motor_ctr_r};
      REG_POSE_LO:   prdata = {16'd0, pose_lo_r};
      REG_POSE_HI:   prdata = {16'd0, pose_hi_r};
      REG_MOTOR_LO:  prdata = {16'd0, motor_lo_r};
      REG_MOTOR_HI:  prdata = {16'd0, motor_hi_r};
      default:       prdata = '0;
    endcase
  end

  // Derive determinant, magnitudes and the singular flag: products, then magnitudes, then the flag
  assign det = 33'(p1_r) - 33'(p2_r);

  always_ff @(posedge clk) begin
    p1_r       <= slot_t'(coupling_r[15:0]) * slot_t'(coupling_r[63:48]);
    p2_r       <= slot_t'(coupling_r[31:16]) * slot_t'(coupling_r[47:32]);
    det_neg_r  <= det[32];
    det_mag_r  <= det[32] ? DMAG_W'(-det) : DMAG_W'(det);
    gain_neg_r <= gain_thr_r[15];
    gain_mag_r <= gain_thr_r[15] ? GMAG_W'(-slot_t'(gain_thr_r[15:0]))
                                 : gain_thr_r[15:0];
    singular_r <= (thr == '0) || (det_mag_r <= thr) ||
                  ({4'd0, gain_mag_r, 12'd0} <= thr);
  end

  assign cfg.c11       = coupling_r[15:0];
  assign cfg.c12       = coupling_r[31:16];
  assign cfg.c21       = coupling_r[47:32];
  assign cfg.c22       = coupling_r[63:48];
  assign cfg.det_neg   = det_neg_r;
  assign cfg.det_mag   = det_mag_r;
  assign cfg.gain_neg  = gain_neg_r;
  assign cfg.gain_mag  = gain_mag_r;
  assign cfg.singular  = singular_r;
  assign cfg.pose_ctr  = pose_ctr_r;
  assign cfg.motor_ctr = motor_ctr_r;
  assign cfg.pose_lo   = pose_lo_r;
  assign cfg.pose_hi   = pose_hi_r;
  assign cfg.motor_lo  = motor_lo_r;
  assign cfg.motor_hi  = motor_hi_r;

endmodule
`default_nettype wire

[rtl/nik_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module nik_front import nik_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv,
  input  wire logic in_valid,
  input  in_word_t  in_word,
  input  cfg_t      cfg,
  output front_t    front
);

  logic v0_r, v1_r, v2_r, v3_r;
  in_word_t w0_r;
  logic pf1_r, pf2_r, pf3_r;
  logic signed [DIFF_W-1:0] dp_r, dr_r, dy1_r, dy2_r;
  logic signed [PROD_W-1:0] m22p_r, m12r_r, m11r_r, m21p_r;
  logic signed [NUM_W-1:0]  n1_r, n2_r;
  logic signed [YNUM_W-1:0] n3_r;
  logic signed [PROD_W:0]   diff1, diff2;
  angle_t pose [3];
  logic pose_fail;

  assign pose[0] = w0_r.pitch_angle;
  assign pose[1] = w0_r.roll_angle;
  assign pose[2] = w0_r.yaw_angle;

  // Check each pose against its inclusive limits
  always_comb begin
    pose_fail = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (DIFF_W'(pose[i]) < DIFF_W'(cfg.pose_lo[i]) ||
          DIFF_W'(pose[i]) > DIFF_W'(cfg.pose_hi[i]))
        pose_fail = 1'b1;
    end
  end

  assign diff1 = (PROD_W+1)'(m22p_r) - (PROD_W+1)'(m12r_r);
  assign diff2 = (PROD_W+1)'(m11r_r) - (PROD_W+1)'(m21p_r);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Capture, offset, multiply, combine
  always_ff @(posedge clk) begin
    if (adv) begin
      w0_r   <= in_word;
      dp_r   <= DIFF_W'(pose[0]) - DIFF_W'(cfg.pose_ctr[0]);
      dr_r   <= DIFF_W'(pose[1]) - DIFF_W'(cfg.pose_ctr[1]);
      dy1_r  <= DIFF_W'(pose[2]) - DIFF_W'(cfg.pose_ctr[2]);
      pf1_r  <= pose_fail;
      m22p_r <= cfg.c22 * dp_r;
      m12r_r <= cfg.c12 * dr_r;
      m11r_r <= cfg.c11 * dr_r;
      m21p_r <= cfg.c21 * dp_r;
      dy2_r  <= dy1_r;
      pf2_r  <= pf1_r;
      n1_r   <= {diff1, {FRAC_SH{1'b0}}};
      n2_r   <= {diff2, {FRAC_SH{1'b0}}};
      n3_r   <= {dy2_r, {FRAC_SH{1'b0}}};
      pf3_r  <= pf2_r;
    end
  end

  assign front.valid     = v3_r;
  assign front.pose_fail = pf3_r;
  assign front.num1      = n1_r;
  assign front.num2      = n2_r;
  assign front.num3      = n3_r;

endmodule
`default_nettype wire

[rtl/nik_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module nik_div import nik_pkg::*; #(
  parameter int N_W = NUM_W,
  parameter int D_W = DMAG_W,
  parameter int Q_W = QUO_W
) (
  input  wire logic                  clk,
  input  wire logic                  adv,
  input  wire logic signed [N_W-1:0] num,
  input  wire logic        [D_W-1:0] den_mag,
  input  wire logic                  den_neg,
  output logic signed [Q_W:0]        quo
);

  localparam int HI_W  = N_W - Q_W;
  localparam int CMP_W = (HI_W > D_W) ? HI_W : D_W;

  logic [N_W-1:0] mag_a_r;
  logic           neg_a_r;
  logic [D_W-1:0] rem_r [Q_W+1];
  logic [Q_W-1:0] shf_r [Q_W+1];
  logic           ovf_r [Q_W+1];
  logic           neg_r [Q_W+1];
  logic [CMP_W-1:0] hi_ext;
  logic [Q_W-1:0]   q_mag;
  logic signed [Q_W:0] quo_r;

  assign hi_ext = CMP_W'(mag_a_r[N_W-1:Q_W]);

  // Take magnitudes, then check the quotient fits its window
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_a_r  <= num[N_W-1] ? N_W'(-num) : N_W'(num);
      neg_a_r  <= num[N_W-1] ^ den_neg;
      ovf_r[0] <= hi_ext >= CMP_W'(den_mag);
      rem_r[0] <= hi_ext[D_W-1:0];
      shf_r[0] <= mag_a_r[Q_W-1:0];
      neg_r[0] <= neg_a_r;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [D_W:0] trial, red;
    logic         take;
    assign trial = {rem_r[k], shf_r[k][Q_W-1]};
    assign take  = trial >= {1'b0, den_mag};
    assign red   = trial - {1'b0, den_mag};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= take ? red[D_W-1:0] : trial[D_W-1:0];
        shf_r[k+1] <= {shf_r[k][Q_W-2:0], take};
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  // Saturate on overflow and apply the sign
  assign q_mag = ovf_r[Q_W] ? {Q_W{1'b1}} : shf_r[Q_W];

  always_ff @(posedge clk) begin
    if (adv)
      quo_r <= neg_r[Q_W] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

[rtl/neck_inverse_kinematics_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake          Word
// in_       in   in_valid/in_stall  in_word   (pitch, roll, yaw)
// out_      out  out_valid/out_stall out_word (three motors, status)
// cfg       in   APB psel/penable   paddr/pwdata/prdata, 64-bit registers
//
// One word per cycle in and out while out_stall does not hold the pipeline;
// the path runs through restoring dividers that retire one quotient bit per stage.
// Reset (rst_n, synchronous) clears the valid bits and loads register defaults.
// The whole pipeline holds while a result waits under out_stall; in_stall
// follows it, so nothing is dropped or repeated.
module neck_inverse_kinematics_core import nik_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  in_word_t                in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_word_t               out_word,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  localparam logic signed [SUM_W-1:0] AMIN =
    {{(SUM_W-ANGLE_WIDTH+1){1'b1}}, {(ANGLE_WIDTH-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] AMAX =
    {{(SUM_W-ANGLE_WIDTH+1){1'b0}}, {(ANGLE_WIDTH-1){1'b1}}};

  cfg_t   cfg;
  front_t front;
  logic   adv;
  logic   v_r  [DIV_LAT];
  logic   pf_r [DIV_LAT];
  logic signed [QUO_W:0] q [3];
  logic signed [SUM_W-1:0] motor [3];
  logic ovf, mrange;
  status_t status;
  logic      out_valid_r;
  out_word_t out_word_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign pready   = 1'b1;

  nik_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  nik_front u_front (
    .clk, .rst_n, .adv, .in_valid, .in_word, .cfg, .front
  );

  nik_div #(.N_W(NUM_W), .D_W(DMAG_W), .Q_W(QUO_W)) u_div1 (
    .clk, .adv, .num(front.num1), .den_mag(cfg.det_mag), .den_neg(cfg.det_neg),
    .quo(q[0])
  );

  nik_div #(.N_W(NUM_W), .D_W(DMAG_W), .Q_W(QUO_W)) u_div2 (
    .clk, .adv, .num(front.num2), .den_mag(cfg.det_mag), .den_neg(cfg.det_neg),
    .quo(q[1])
  );

  nik_div #(.N_W(YNUM_W), .D_W(GMAG_W), .Q_W(QUO_W)) u_div3 (
    .clk, .adv, .num(front.num3), .den_mag(cfg.gain_mag), .den_neg(cfg.gain_neg),
    .quo(q[2])
  );

  // Carry valid and pose flag alongside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= front.valid;
      for (int i = 1; i < DIV_LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pf_r[0] <= front.pose_fail;
      for (int i = 1; i < DIV_LAT; i++) pf_r[i] <= pf_r[i-1];
    end
  end

  // Add centers, range checks, status priority
  always_comb begin
    ovf    = 1'b0;
    mrange = 1'b0;
    for (int i = 0; i < 3; i++) begin
      motor[i] = SUM_W'(cfg.motor_ctr[i]) + SUM_W'(q[i]);
      if (motor[i] < AMIN || motor[i] > AMAX) ovf = 1'b1;
      if (motor[i] < SUM_W'(cfg.motor_lo[i]) || motor[i] > SUM_W'(cfg.motor_hi[i]))
        mrange = 1'b1;
    end
    if (cfg.singular)                 status = ST_SINGULAR;
    else if (pf_r[DIV_LAT-1])         status = ST_POSE_RANGE;
    else if (ovf)                     status = ST_OVERFLOW;
    else if (mrange)                  status = ST_MOTOR_RANGE;
    else                              status = ST_OK;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= v_r[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r.status_code  <= status;
      out_word_r.first_motor  <= (status == ST_OK) ? motor[0][ANGLE_WIDTH-1:0] : '0;
      out_word_r.second_motor <= (status == ST_OK) ? motor[1][ANGLE_WIDTH-1:0] : '0;
      out_word_r.third_motor  <= (status == ST_OK) ? motor[2][ANGLE_WIDTH-1:0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_word_r.status_code != ST_OK) |->
      (out_word_r.first_motor == '0) && (out_word_r.second_motor == '0) &&
      (out_word_r.third_motor == '0))
    else $error("motor word not cleared on error");
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid survives reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(v_r[DIV_LAT-1]))
    else $error("pipeline advanced under stall");
`endif

endmodule
`default_nettype wire
